// ----- rtl/core/scd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// scd_pkg
// Types, codes and constants shared by the sector cache directory modules.
// ----------------------------------------------------------------------------
package scd_pkg;

    localparam int unsigned SLOTS_DEF  = 16;
    localparam int unsigned DRIVES_DEF = 4;
    localparam int unsigned NUM_REGS   = 4;

    typedef enum logic [2:0] {
        CMD_OPEN  = 3'd0,
        CMD_READ  = 3'd1,
        CMD_MARK  = 3'd2,
        CMD_WB    = 3'd3,
        CMD_FLUSH = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_REPLY = 2'd0,
        KIND_WB    = 2'd1,
        KIND_LOAD  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_MISS    = 2'd1,
        ST_RANGE   = 2'd2,
        ST_ABSENT  = 2'd3
    } t_status;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [1:0]  drive;
        logic [31:0] sector;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  out_drive;
        logic [31:0] out_sector;
        logic [3:0]  slot;
        logic [1:0]  status;
        logic        clear_buffer;
        logic        last;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_DECIDE,
        S_REQ,
        S_SWEEP,
        S_REPLY
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;   // capture the input item
        logic match;       // register match result
        logic apply;       // update slot state for the item
        logic sweep_start; // start a flush walk
        logic sweep_step;  // advance the flush walk
        logic emit_req;    // load the output register with the request
        logic emit_reply;  // load the output register with the reply
    } t_ctrl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_flush;
        logic need_req;    // request goes ahead of the reply
        logic sweep_hit;   // current walk slot must be written back
        logic sweep_done;  // walk has covered all slots in use
    } t_stat;

endpackage
`default_nettype wire

// ----- rtl/core/scd_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// scd_ctrl
// Command sequencer: steps one item through match, update, requests and reply.
// ----------------------------------------------------------------------------
module scd_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic          i_out_free,
    input  wire scd_pkg::t_stat i_stat,
    output scd_pkg::t_ctrl     o_ctrl
);
    import scd_pkg::*;

    t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_ctrl     = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctrl.load_item = 1'b1;
                    n_state = S_MATCH;
                end
            end
            S_MATCH: begin
                o_ctrl.match = 1'b1;
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_stat.is_flush) begin
                    o_ctrl.sweep_start = 1'b1;
                    n_state = S_SWEEP;
                end else if (i_stat.need_req) begin
                    n_state = S_REQ;
                end else begin
                    o_ctrl.apply = 1'b1;
                    n_state = S_REPLY;
                end
            end
            S_REQ: begin
                if (i_out_free) begin
                    o_ctrl.emit_req = 1'b1;
                    o_ctrl.apply    = 1'b1;
                    n_state = S_REPLY;
                end
            end
            S_SWEEP: begin
                if (i_stat.sweep_done) begin
                    n_state = S_REPLY;
                end else if (!i_stat.sweep_hit) begin
                    o_ctrl.sweep_step = 1'b1;
                end else if (i_out_free) begin
                    o_ctrl.emit_req   = 1'b1;
                    o_ctrl.sweep_step = 1'b1;
                end
            end
            S_REPLY: begin
                if (i_out_free) begin
                    o_ctrl.emit_reply = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/core/scd_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// scd_datapath
// Slot directory, drive sizes, associative match, flush walk and output item.
// ----------------------------------------------------------------------------
module scd_datapath #(
    parameter int unsigned SLOTS  = scd_pkg::SLOTS_DEF,
    parameter int unsigned DRIVES = scd_pkg::DRIVES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data,
    input  wire scd_pkg::t_in_item  i_item,
    input  wire scd_pkg::t_ctrl     i_ctrl,
    output scd_pkg::t_stat          o_stat,
    output logic                    o_out_free,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output scd_pkg::t_out_item      o_out_item
);
    import scd_pkg::*;

    localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned CW = $clog2(SLOTS + 1);

    // Drive size registers.
    logic [31:0] r_size [NUM_REGS];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NUM_REGS; j++) r_size[j] <= '0;
        end else if (i_cfg_we) begin
            r_size[i_cfg_index] <= i_cfg_data;
        end
    end

    function automatic logic [31:0] size_of(input logic [1:0] d, input logic [31:0] s0,
                                            input logic [31:0] s1, input logic [31:0] s2,
                                            input logic [31:0] s3);
        logic [31:0] v;
        case (d)
            2'd0:    v = s0;
            2'd1:    v = s1;
            2'd2:    v = s2;
            default: v = s3;
        endcase
        if (32'(d) >= DRIVES) v = '0;
        return v;
    endfunction

    // Slot directory.
    logic [1:0]       r_sdrv [SLOTS];
    logic [31:0]      r_ssec [SLOTS];
    logic [SLOTS-1:0] r_loaded, r_dirty;
    logic [CW-1:0]    r_used;
    logic [SW-1:0]    r_vptr;

    t_in_item         r_item;
    logic             r_hit;
    logic [SW-1:0]    r_hidx;
    logic [CW-1:0]    r_walk;
    logic             r_loaded_prev;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_item) r_item <= i_item;
    end

    // Associative match over slots in use, lowest index wins.
    logic          m_hit;
    logic [SW-1:0] m_idx;
    always_comb begin
        m_hit = 1'b0;
        m_idx = '0;
        for (int j = SLOTS - 1; j >= 0; j--) begin
            if (CW'(j) < r_used && r_sdrv[j] == r_item.drive && r_ssec[j] == r_item.sector) begin
                m_hit = 1'b1;
                m_idx = SW'(j);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.match) begin
            r_hit  <= m_hit;
            r_hidx <= m_idx;
        end
    end

    // Decisions on the registered match.
    logic [31:0]   c_size;
    logic          c_full;
    logic [SW-1:0] c_new;
    logic [SW-1:0] c_vnext;
    logic          c_open_ok;
    logic          c_victim_wb;
    logic          c_hd, c_hl;
    always_comb begin
        c_size    = size_of(r_item.drive, r_size[0], r_size[1], r_size[2], r_size[3]);
        c_full    = (r_used == CW'(SLOTS));
        c_new     = c_full ? r_vptr : r_used[SW-1:0];
        c_vnext   = (32'(r_vptr) == SLOTS - 1) ? '0 : r_vptr + SW'(1);
        c_open_ok = !r_hit && c_size != 0 && r_item.sector < c_size;
        c_victim_wb = c_full && r_dirty[r_vptr] &&
                      size_of(r_sdrv[r_vptr], r_size[0], r_size[1], r_size[2], r_size[3]) != 0;
        c_hd = r_dirty[r_hidx];
        c_hl = r_loaded[r_hidx];
    end

    // Flush walk slot.
    logic [SW-1:0] w_idx;
    logic [SW:0]   w_sum;
    always_comb begin
        w_sum = {1'b0, r_vptr} + r_walk[SW-1:0];
        if (SLOTS == 1) w_idx = '0;
        else if (32'(w_sum) >= SLOTS) w_idx = SW'(32'(w_sum) - SLOTS);
        else w_idx = w_sum[SW-1:0];
    end

    always_comb begin
        o_stat.is_flush = (r_item.cmd == CMD_FLUSH);
        case (r_item.cmd)
            CMD_OPEN: o_stat.need_req = c_open_ok && c_victim_wb;
            CMD_READ: o_stat.need_req = r_hit && !c_hl && c_size != 0;
            CMD_WB:   o_stat.need_req = r_hit && c_hd && c_size != 0;
            default:  o_stat.need_req = 1'b0;
        endcase
        o_stat.sweep_done = (r_walk == r_used);
        o_stat.sweep_hit  = r_dirty[w_idx] &&
                     size_of(r_sdrv[w_idx], r_size[0], r_size[1], r_size[2], r_size[3]) != 0;
    end

    // State updates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded <= '0;
            r_dirty  <= '0;
            r_used   <= '0;
            r_vptr   <= '0;
            r_walk   <= '0;
        end else begin
            if (i_ctrl.sweep_start) r_walk <= '0;
            if (i_ctrl.sweep_step) begin
                r_walk <= r_walk + CW'(1);
                if (i_ctrl.emit_req) r_dirty[w_idx] <= 1'b0;
            end
            if (i_ctrl.apply) begin
                case (r_item.cmd)
                    CMD_OPEN: if (c_open_ok) begin
                        r_sdrv[c_new]   <= r_item.drive;
                        r_ssec[c_new]   <= r_item.sector;
                        r_loaded[c_new] <= 1'b0;
                        r_dirty[c_new]  <= 1'b0;
                        if (c_full) r_vptr <= c_vnext;
                        else r_used <= r_used + CW'(1);
                    end
                    CMD_READ: if (r_hit) r_loaded[r_hidx] <= 1'b1;
                    CMD_MARK: if (r_hit) begin
                        r_loaded[r_hidx] <= 1'b1;
                        r_dirty[r_hidx]  <= 1'b1;
                    end
                    CMD_WB: if (r_hit && c_size != 0) r_dirty[r_hidx] <= 1'b0;
                    default: ;
                endcase
            end
        end
    end

    // Output register.
    logic r_ov;
    t_out_item r_out;
    assign o_out_free  = !r_ov || i_out_ready;
    assign o_out_valid = r_ov;
    assign o_out_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_ctrl.emit_req || i_ctrl.emit_reply) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.emit_req) begin
            r_out.status       <= ST_OK;
            r_out.clear_buffer <= 1'b0;
            r_out.last         <= 1'b0;
            if (r_item.cmd == CMD_FLUSH) begin
                r_out.kind       <= KIND_WB;
                r_out.out_drive  <= r_sdrv[w_idx];
                r_out.out_sector <= r_ssec[w_idx];
                r_out.slot       <= 4'(w_idx);
            end else if (r_item.cmd == CMD_OPEN) begin
                r_out.kind       <= KIND_WB;
                r_out.out_drive  <= r_sdrv[r_vptr];
                r_out.out_sector <= r_ssec[r_vptr];
                r_out.slot       <= 4'(r_vptr);
            end else begin
                r_out.kind       <= (r_item.cmd == CMD_READ) ? KIND_LOAD : KIND_WB;
                r_out.out_drive  <= r_item.drive;
                r_out.out_sector <= r_item.sector;
                r_out.slot       <= 4'(r_hidx);
            end
        end else if (i_ctrl.emit_reply) begin
            r_out.kind         <= KIND_REPLY;
            r_out.last         <= 1'b1;
            r_out.clear_buffer <= 1'b0;
            r_out.out_drive    <= r_item.drive;
            r_out.out_sector   <= r_item.sector;
            r_out.slot         <= r_hit ? 4'(r_hidx) : 4'd0;
            r_out.status       <= ST_OK;
            case (r_item.cmd)
                CMD_OPEN: if (!r_hit) begin
                    r_out.slot <= 4'd0;
                    if (c_size == 0) r_out.status <= ST_ABSENT;
                    else if (r_item.sector >= c_size) r_out.status <= ST_RANGE;
                    else begin
                        // The slot is the one just assigned, reckoned back from the counters after they moved.
                        r_out.clear_buffer <= 1'b1;
                        r_out.slot <= 4'(r_used == CW'(SLOTS) ?
                                         ((32'(r_vptr) == 0) ? SW'(SLOTS - 1) : r_vptr - SW'(1))
                                         : r_used[SW-1:0] - SW'(1));
                    end
                end
                CMD_READ, CMD_MARK: if (!r_hit) r_out.status <= ST_MISS;
                    else if (r_item.cmd == CMD_READ && !r_loaded_prev && c_size == 0)
                        r_out.status <= ST_ABSENT;
                CMD_WB: if (!r_hit) r_out.status <= ST_MISS;
                    else if (c_hd && c_size == 0) r_out.status <= ST_ABSENT;
                CMD_FLUSH: begin
                    r_out.out_drive  <= '0;
                    r_out.out_sector <= '0;
                    r_out.slot       <= '0;
                end
                default: r_out.slot <= '0;
            endcase
        end
    end

    // Loaded flag of the hit slot as it was before this item updated it.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.match) r_loaded_prev <= 1'b0;
        else if (i_ctrl.apply) r_loaded_prev <= c_hl;
    end

endmodule
`default_nettype wire

// ----- rtl/core/sector_cache_directory.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sector_cache_directory
// Sector cache directory: associative slot lookup with FIFO replacement.
// The reply is loaded into the output register in the reply state, after the
// match and decide states, any request ahead of it, and any output stall.
// Takes a new item only once the previous reply is emitted. Flush walks the
// slots in use, one slot per cycle unless a write-back waits for the output.
// Reset clears the slot flags and counters; no clearing pass.
// ----------------------------------------------------------------------------
module sector_cache_directory #(
    parameter int unsigned SLOTS  = scd_pkg::SLOTS_DEF,
    parameter int unsigned DRIVES = scd_pkg::DRIVES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire scd_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output scd_pkg::t_out_item      o_out_item
);
    import scd_pkg::*;

    t_ctrl ctrl;
    t_stat stat;
    logic  out_free;

    // Sequencer.
    scd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_out_free (out_free),
        .i_stat     (stat),
        .o_ctrl     (ctrl)
    );

    // Directory and output register.
    scd_datapath #(.SLOTS(SLOTS), .DRIVES(DRIVES)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (i_in_item),
        .i_ctrl      (ctrl),
        .o_stat      (stat),
        .o_out_free  (out_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
`default_nettype wire

// ----- tb/tb_sector_cache_directory.sv -----
// ----------------------------------------------------------------------------
// tb_sector_cache_directory
// Drives open, read, mark-written, write-back and flush commands into the
// sector cache directory, models the expected slot state, and compares every
// result item field by field, under random idling on both handshakes.
// ----------------------------------------------------------------------------
module tb_sector_cache_directory;
    timeunit 1ns;
    timeprecision 1ps;
    import scd_pkg::*;

    // Predicts directory results and holds the results still owed.
    class dir_scoreboard;
        logic [31:0] drv_size [4];
        logic [1:0]  s_drive [16];
        logic [31:0] s_sector [16];
        bit          s_loaded [16];
        bit          s_dirty [16];
        int          in_use;
        int          victim;
        t_out_item   owed [$];
        int          errors;
        int          checked;

        function void clear();
            for (int i = 0; i < 16; i++) begin
                s_loaded[i] = 0;
                s_dirty[i] = 0;
                s_drive[i] = 0;
                s_sector[i] = 0;
            end
            for (int i = 0; i < 4; i++) drv_size[i] = 0;
            in_use = 0;
            victim = 0;
            errors = 0;
            checked = 0;
        endfunction

        function void push(logic [1:0] k, logic [1:0] d, logic [31:0] s, int sl,
                           logic [1:0] st, bit clr, bit lst);
            t_out_item o;
            o.kind = k;
            o.out_drive = d;
            o.out_sector = s;
            o.slot = sl[3:0];
            o.status = st;
            o.clear_buffer = clr;
            o.last = lst;
            owed.push_back(o);
        endfunction

        function void write_back(int i);
            if (s_dirty[i] && drv_size[s_drive[i]] != 0) begin
                s_dirty[i] = 0;
                push(KIND_WB, s_drive[i], s_sector[i], i, ST_OK, 0, 0);
            end
        endfunction

        // Notes an accepted item and queues the results it causes.
        function void note_input(t_in_item it);
            int hit = -1;
            int k;
            logic [1:0] d = it.drive;
            logic [31:0] s = it.sector;
            for (int i = 0; i < in_use; i++)
                if (hit < 0 && s_drive[i] == d && s_sector[i] == s) hit = i;
            case (it.cmd)
                CMD_OPEN: begin
                    if (hit >= 0) push(KIND_REPLY, d, s, hit, ST_OK, 0, 1);
                    else if (drv_size[d] == 0) push(KIND_REPLY, d, s, 0, ST_ABSENT, 0, 1);
                    else if (s >= drv_size[d]) push(KIND_REPLY, d, s, 0, ST_RANGE, 0, 1);
                    else begin
                        if (in_use < 16) begin
                            k = in_use;
                            in_use++;
                        end else begin
                            k = victim;
                            victim = (k + 1) % 16;
                            write_back(k);
                        end
                        s_drive[k] = d;
                        s_sector[k] = s;
                        s_loaded[k] = 0;
                        s_dirty[k] = 0;
                        push(KIND_REPLY, d, s, k, ST_OK, 1, 1);
                    end
                end
                CMD_READ: begin
                    if (hit < 0) push(KIND_REPLY, d, s, 0, ST_MISS, 0, 1);
                    else if (s_loaded[hit]) push(KIND_REPLY, d, s, hit, ST_OK, 0, 1);
                    else begin
                        s_loaded[hit] = 1;
                        if (drv_size[d] == 0) push(KIND_REPLY, d, s, hit, ST_ABSENT, 0, 1);
                        else begin
                            push(KIND_LOAD, d, s, hit, ST_OK, 0, 0);
                            push(KIND_REPLY, d, s, hit, ST_OK, 0, 1);
                        end
                    end
                end
                CMD_MARK: begin
                    if (hit < 0) push(KIND_REPLY, d, s, 0, ST_MISS, 0, 1);
                    else begin
                        s_dirty[hit] = 1;
                        s_loaded[hit] = 1;
                        push(KIND_REPLY, d, s, hit, ST_OK, 0, 1);
                    end
                end
                CMD_WB: begin
                    if (hit < 0) push(KIND_REPLY, d, s, 0, ST_MISS, 0, 1);
                    else if (s_dirty[hit] && drv_size[d] == 0)
                        push(KIND_REPLY, d, s, hit, ST_ABSENT, 0, 1);
                    else begin
                        write_back(hit);
                        push(KIND_REPLY, d, s, hit, ST_OK, 0, 1);
                    end
                end
                CMD_FLUSH: begin
                    for (int i = 0; i < in_use; i++) write_back((victim + i) % 16);
                    push(KIND_REPLY, 0, 0, 0, ST_OK, 0, 1);
                end
                default: push(KIND_REPLY, d, s, 0, ST_OK, 0, 1);
            endcase
        endfunction

        // Compares one accepted result with the oldest one owed.
        function void check_result(t_out_item got);
            t_out_item exp_item;
            checked++;
            if (owed.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", got);
                return;
            end
            exp_item = owed.pop_front();
            if (got !== exp_item) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch: expected kind %0d drv %0d sec %h slot %0d st %0d %s",
                             exp_item.kind, exp_item.out_drive, exp_item.out_sector,
                             exp_item.slot, exp_item.status,
                             $sformatf("clr %0d last %0d", exp_item.clear_buffer,
                                       exp_item.last));
                    $display("          got kind %0d drv %0d sec %h slot %0d st %0d %s",
                             got.kind, got.out_drive, got.out_sector, got.slot, got.status,
                             $sformatf("clr %0d last %0d", got.clear_buffer, got.last));
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    t_in_item    in_item;
    logic        out_valid;
    logic        out_ready;
    t_out_item   out_item;

    dir_scoreboard board;
    int send_idle_pct;
    int recv_idle_pct;
    int items_sent;

    sector_cache_directory dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    // Clock with a 10 ns period.
    initial clk = 0;
    always begin
        #5 clk = 1;
        #5 clk = 0;
    end

    // Result side: random stall, check every accepted result.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) board.check_result(out_item);
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Sends one item, with a random idle gap before it. Valid stays high into
    // the next item when there is no gap.
    task automatic send_item(logic [2:0] c, logic [1:0] d, logic [31:0] s);
        t_in_item it;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 0;
            @(posedge clk);
        end
        it.cmd = c;
        it.drive = d;
        it.sector = s;
        in_item <= it;
        in_valid <= 1;
        do @(posedge clk); while (!in_ready);
        board.note_input(it);
        items_sent++;
    endtask

    // Waits until every owed result has arrived, plus a few idle cycles.
    task automatic drain();
        in_valid <= 0;
        while (board.owed.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 0;
        board.drv_size[idx] = val;
        @(posedge clk);
    endtask

    // Mostly sectors near a small pool so that hits and dirty evictions
    // occur often; some full-range values.
    function automatic logic [31:0] pick_sector();
        case ($urandom_range(9))
            0: return $urandom();
            1: return 32'hFFFF_FFFF - $urandom_range(3);
            default: return $urandom_range(23);
        endcase
    endfunction

    task automatic random_phase(int n);
        logic [2:0] c;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(19))
                0, 1, 2, 3, 4, 5: c = CMD_OPEN;
                6, 7, 8, 9: c = CMD_READ;
                10, 11, 12, 13: c = CMD_MARK;
                14, 15, 16: c = CMD_WB;
                17: c = CMD_FLUSH;
                default: c = 3'($urandom_range(7, 5));
            endcase
            send_item(c, 2'($urandom_range(3)), pick_sector());
        end
    endtask

    initial begin
        board = new();
        board.clear();
        rst_n = 0;
        cfg_we = 0;
        cfg_index = 0;
        cfg_data = 0;
        in_valid = 0;
        in_item = '0;
        out_ready = 0;
        send_idle_pct = 17;
        recv_idle_pct = 72;
        items_sent = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: all drives absent first, then configured.
        send_item(CMD_OPEN, 0, 0);
        send_item(CMD_READ, 1, 5);
        send_item(CMD_FLUSH, 2, 7);
        send_item(3'd5, 3, 32'hFFFF_FFFF);
        drain();
        write_reg(0, 32'hFFFF_FFFF);
        write_reg(1, 16);
        write_reg(2, 1);
        write_reg(3, 0);
        send_item(CMD_OPEN, 0, 32'hFFFF_FFFE);
        send_item(CMD_OPEN, 0, 32'hFFFF_FFFF);
        send_item(CMD_OPEN, 1, 16);
        send_item(CMD_OPEN, 1, 15);
        send_item(CMD_OPEN, 2, 0);
        send_item(CMD_OPEN, 3, 0);
        send_item(CMD_OPEN, 2, 0);
        send_item(CMD_READ, 2, 0);
        send_item(CMD_READ, 2, 0);
        send_item(CMD_MARK, 1, 15);
        send_item(CMD_MARK, 1, 3);
        send_item(CMD_WB, 1, 15);
        send_item(CMD_WB, 1, 15);
        send_item(CMD_MARK, 0, 32'hFFFF_FFFE);
        send_item(CMD_FLUSH, 0, 0);
        send_item(3'd7, 1, 32'h5555_AAAA);
        drain();

        // Drive 2 vanishes while its slot is dirty and loaded.
        send_item(CMD_MARK, 2, 0);
        send_item(CMD_OPEN, 1, 2);
        drain();
        write_reg(2, 0);
        send_item(CMD_WB, 2, 0);
        send_item(CMD_READ, 1, 2);
        send_item(CMD_FLUSH, 0, 0);
        drain();

        // Random phases with varied drive sizes, extremes included.
        write_reg(0, 24);
        write_reg(1, 32'hFFFF_FFFF);
        write_reg(2, 10);
        write_reg(3, 0);
        random_phase(60);
        drain();
        send_idle_pct = 72;
        recv_idle_pct = 17;
        write_reg(2, 0);
        write_reg(3, 20);
        random_phase(60);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(0, 0);
        write_reg(2, 32'hFFFF_FFFF);
        random_phase(60);
        send_item(CMD_FLUSH, 0, 0);
        drain();

        $display("Covered %0d commands and %0d result items over six drive settings.",
                 items_sent, board.checked);
        if (board.errors == 0 && board.owed.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
